// ===== sv/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper speed ramp package
// Shared types, constants and the step period table for the ramp generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

    localparam int POS_W    = 16;
    localparam int TIMER_W  = 16;
    localparam int LEVEL_W  = 4;
    localparam int PERIOD_W = 14;
    localparam int CFG_W    = 16;

    // Operation codes carried in the input tuser.
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_WINDOW_LOW  = 1'b0;
    localparam logic CFG_WINDOW_HIGH = 1'b1;

    localparam logic [CFG_W-1:0]    WINDOW_LOW_RST  = 16'd20;
    localparam logic [CFG_W-1:0]    WINDOW_HIGH_RST = 16'd200;
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 14'd10000;

    typedef struct packed {
        logic [TIMER_W-1:0]     timer_count;
        logic signed [POS_W-1:0] target_pos;
        logic                   opcode;
    } item_t;

    typedef struct packed {
        logic                    pulse_out_enable;
        logic                    dir_out;
        logic                    running;
        logic [LEVEL_W-1:0]      speed_level;
        logic signed [POS_W-1:0] position;
        logic                    stepped;
        logic [PERIOD_W-1:0]     step_period;
    } result_t;

    typedef struct packed {
        logic [CFG_W-1:0] window_low;
        logic [CFG_W-1:0] window_high;
    } window_t;

    // Levels past the end of the table read the fastest entry.
    function automatic logic [PERIOD_W-1:0] period_lookup(input logic [LEVEL_W-1:0] lvl);
        logic [PERIOD_W-1:0] p;
        unique case (lvl)
            4'd0:    p = 14'd10000;
            4'd1:    p = 14'd8000;
            4'd2:    p = 14'd6500;
            4'd3:    p = 14'd5000;
            4'd4:    p = 14'd2000;
            4'd5:    p = 14'd500;
            4'd6:    p = 14'd400;
            4'd7:    p = 14'd300;
            4'd8:    p = 14'd200;
            default: p = 14'd100;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssr_in_reg.sv =====
// ----------------------------------------------------------------------------
// Stepper speed ramp input register
// Holds one accepted input transaction until the step stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_in_reg
    import ssr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  take,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register refills in the same cycle that it is emptied.
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== sv/ssr_step.sv =====
// ----------------------------------------------------------------------------
// Stepper speed ramp step stage
// Motion state, ramp update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_step
    import ssr_pkg::*;
#(
    parameter int NUM_LEVELS = 10
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire window_t window,
    input  wire logic    item_valid,
    input  wire item_t   item,
    output logic         take,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      result
);

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(NUM_LEVELS - 1);

    logic [POS_W-1:0]    position_reg, position_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                run_reg, run_next;
    logic                dir_reg, dir_next;
    logic                pulse_en_reg, pulse_en_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic                out_valid_reg, out_valid_next;
    result_t             result_reg, result_next;

    logic signed [POS_W:0]   pos_ext;
    logic signed [POS_W:0]   tgt_ext;
    logic signed [POS_W:0]   diff;
    logic signed [POS_W+1:0] remain;
    logic signed [POS_W+1:0] lvl_ext;
    logic                    in_window;
    logic                    start;
    logic                    stepped;

    assign take = item_valid && (!out_valid_reg || out_ready);

    assign pos_ext = {position_reg[POS_W-1], position_reg};
    assign tgt_ext = {item.target_pos[POS_W-1], item.target_pos};
    assign diff    = dir_reg ? (tgt_ext - pos_ext) : (pos_ext - tgt_ext);
    assign remain  = {diff[POS_W], diff} - (POS_W+2)'(1);
    assign lvl_ext = {{(POS_W+2-LEVEL_W){1'b0}}, level_reg};

    assign in_window = (item.timer_count > window.window_low)
                    && (item.timer_count < window.window_high);
    assign start     = !run_reg && (tgt_ext != pos_ext) && in_window;
    assign stepped   = (item.opcode == OP_STEP) && run_reg;

    always_comb
    begin
        position_next = position_reg;
        level_next    = level_reg;
        run_next      = run_reg;
        dir_next      = dir_reg;
        pulse_en_next = pulse_en_reg;
        period_next   = period_reg;
        unique case (item.opcode)
            OP_STEP:
            begin
                if (run_reg)
                begin
                    priority if (remain > lvl_ext && level_reg < LEVEL_MAX)
                    begin
                        level_next = level_reg + LEVEL_W'(1);
                    end
                    else if (remain < lvl_ext && level_reg != '0)
                    begin
                        level_next = level_reg - LEVEL_W'(1);
                    end
                    else
                    begin
                        level_next = level_reg;
                    end
                    position_next = dir_reg ? position_reg + POS_W'(1)
                                            : position_reg - POS_W'(1);
                    period_next   = period_lookup(level_next);
                    if (level_next == '0)
                    begin
                        run_next = 1'b0;
                    end
                end
            end
            OP_POLL:
            begin
                priority if (start)
                begin
                    dir_next      = tgt_ext > pos_ext;
                    run_next      = 1'b1;
                    pulse_en_next = 1'b1;
                end
                else if (level_reg == '0 && !run_reg && in_window)
                begin
                    pulse_en_next = 1'b0;
                end
                else
                begin
                    pulse_en_next = pulse_en_reg;
                end
            end
            default:
            begin
                position_next = position_reg;
            end
        endcase
    end

    always_comb
    begin
        result_next.step_period      = period_next;
        result_next.stepped          = stepped;
        result_next.position         = position_next;
        result_next.speed_level      = level_next;
        result_next.running          = run_next;
        result_next.dir_out          = dir_next;
        result_next.pulse_out_enable = pulse_en_next;
    end

    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            level_reg     <= '0;
            run_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            pulse_en_reg  <= 1'b1;
            period_reg    <= PERIOD_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                position_reg <= position_next;
                level_reg    <= level_next;
                run_reg      <= run_next;
                dir_reg      <= dir_next;
                pulse_en_reg <= pulse_en_next;
                period_reg   <= period_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ===== sv/stepper_speed_ramp.sv =====
// ----------------------------------------------------------------------------
// Stepper speed ramp
// Trapezoidal speed ramp generator for a stepper motor position mover.
// ----------------------------------------------------------------------------
// Each input transaction produces exactly one result transaction. A step tick
// moves a running motor one step toward the target, adapting the speed level
// to the remaining distance and reporting the step period of the new level; a
// start poll starts motion when idle and the timer count lies inside the
// window, or, with the target reached, disconnects the pulse output when idle
// at level zero inside the window. The block takes one transaction per clock
// while no result waits downstream: an input register feeds the combinational
// ramp logic that updates the motion state and loads the output register.
// While a result waits downstream the input register takes one more
// transaction and then holds the input off until the result is accepted.
// Window registers are written through cfg_wen, cfg_index and cfg_data; the
// user must write them only while the block is idle, as it does not enforce this.
`default_nettype none

module stepper_speed_ramp
    import ssr_pkg::*;
#(
    parameter int NUM_LEVELS = 10
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] target_pos, [31:16] timer_count
    input  wire logic [31:0] s_tdata,
    // [0] opcode
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [13:0] step_period, [14] stepped, [30:15] position, [34:31] speed_level,
    // [35] running, [36] dir_out, [37] pulse_out_enable, [39:38] zero
    output logic [39:0]      m_tdata
);

    window_t window_reg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg.window_low  <= WINDOW_LOW_RST;
            window_reg.window_high <= WINDOW_HIGH_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_WINDOW_LOW:  window_reg.window_low  <= cfg_data;
                CFG_WINDOW_HIGH: window_reg.window_high <= cfg_data;
                default:         window_reg.window_low  <= window_reg.window_low;
            endcase
        end
    end

    assign in_item.opcode      = s_tuser;
    assign in_item.target_pos  = s_tdata[15:0];
    assign in_item.timer_count = s_tdata[31:16];

    ssr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    ssr_step #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .window     (window_reg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    assign m_tdata = {2'b00, result};

`ifndef SYNTHESIS
    // The reported level never passes the top of the ramp.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:31] <= LEVEL_W'(NUM_LEVELS - 1)))
        else $error("speed level above ramp maximum");

    // A step that ends motion has ramped all the way down.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[14] && !m_tdata[35]) |-> (m_tdata[34:31] == '0))
        else $error("motion stopped at nonzero level");

    // An empty input register always accepts a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid |-> s_tready)
        else $error("input stalled while empty");

    // A taken item always yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> m_tvalid)
        else $error("result lost after take");
`endif

endmodule

`default_nettype wire
